// ===== design/merge_sort_engine_core_assert.svh =====
// Assertion macros shared by the sorter RTL.
`ifndef MERGE_SORT_ENGINE_CORE_ASSERT_SVH
`define MERGE_SORT_ENGINE_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define MSE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("merge sort engine: same-cycle check failed");

`define MSE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("merge sort engine: next-cycle check failed");

`else

`define MSE_ASSERT_SAME(label, clk, rst_n, ante, cons)

`define MSE_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/mse_pkg.sv =====
`default_nettype none

package mse_pkg;

    // Batch handoff from the loader to the sorter.
    typedef struct packed {
        logic go;
        logic ovf;
    } t_batch_ctl;

endpackage

`default_nettype wire

// ===== design/mse_store.sv =====
`default_nettype none

module mse_store #(
    parameter int MAX_ITEMS = 64,
    parameter int WORD_BITS = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_we,
    input  wire logic [$clog2(MAX_ITEMS)-1:0] i_waddr,
    input  wire logic [WORD_BITS-1:0]         i_wdata,
    input  wire logic [$clog2(MAX_ITEMS)-1:0] i_raddr0,
    input  wire logic [$clog2(MAX_ITEMS)-1:0] i_raddr1,
    output logic      [WORD_BITS-1:0]         o_rdata0,
    output logic      [WORD_BITS-1:0]         o_rdata1
);

    logic [WORD_BITS-1:0] r_mem [MAX_ITEMS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata0 <= r_mem[i_raddr0];
        o_rdata1 <= r_mem[i_raddr1];
    end

endmodule

`default_nettype wire

// ===== design/mse_sorter.sv =====
`default_nettype none

`include "merge_sort_engine_core_assert.svh"

module mse_sorter #(
    parameter int MAX_ITEMS = 64,
    parameter int WORD_BITS = 32
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire mse_pkg::t_batch_ctl              i_ctl,
    input  wire logic [$clog2(MAX_ITEMS+1)-1:0]   i_count,
    input  wire logic                             i_load_we,
    input  wire logic [$clog2(MAX_ITEMS)-1:0]     i_load_addr,
    input  wire logic [WORD_BITS-1:0]             i_load_data,
    output logic                                  o_active,
    output logic                                  o_strobe,
    output logic signed [WORD_BITS-1:0]           o_value_res,
    output logic                                  o_last_res,
    output logic                                  o_overflow
);

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int WW = CW + 1;
    localparam int SW = WW + 2;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_INIT  = 2'd1;
    localparam logic [1:0] S_MERGE = 2'd2;
    localparam logic [1:0] S_OUT   = 2'd3;

    logic [1:0]           r_state;
    logic [CW-1:0]        r_n;
    logic                 r_ovf;
    logic [WW-1:0]        r_width;
    logic [CW-1:0]        r_lo;
    logic [CW-1:0]        r_mid;
    logic [CW-1:0]        r_hi;
    logic [CW-1:0]        r_i;
    logic [CW-1:0]        r_j;
    logic [CW-1:0]        r_k;
    logic                 r_src_b;
    logic [WORD_BITS-1:0] r_head_a;
    logic [WORD_BITS-1:0] r_head_b;
    logic                 r_load_a;
    logic                 r_load_b;
    logic                 r_strobe;
    logic                 r_out_last;

    logic [WORD_BITS-1:0] a_rd0, a_rd1, b_rd0, b_rd1;
    logic [WORD_BITS-1:0] rd0, rd1;
    logic [WORD_BITS-1:0] cur_a, cur_b;
    logic                 a_ok, b_ok, take_a;
    logic [CW-1:0]        n_i, n_j;
    logic [SW-1:0]        sum_mid, sum_hi, next_lo;
    logic [CW-1:0]        c_mid, c_hi;
    logic [WW-1:0]        n_width;
    logic                 mrg_we;
    logic [WORD_BITS-1:0] mrg_wdata;
    logic [AW-1:0]        raddr0, raddr1;
    logic                 a_we, b_we;
    logic [AW-1:0]        a_waddr;
    logic [WORD_BITS-1:0] a_wdata;
    logic                 merge_done;

    always_comb begin
        rd0 = r_src_b ? b_rd0 : a_rd0;
        rd1 = r_src_b ? b_rd1 : a_rd1;
        // A head just advanced takes the word read last cycle.
        cur_a = r_load_a ? rd0 : r_head_a;
        cur_b = r_load_b ? rd1 : r_head_b;
        a_ok = (r_i < r_mid);
        b_ok = (r_j < r_hi);
        // Left run wins ties to keep arrival order.
        take_a = a_ok && (!b_ok || ($signed(cur_a) <= $signed(cur_b)));
        n_i = take_a ? r_i + CW'(1) : r_i;
        n_j = take_a ? r_j : r_j + CW'(1);
        mrg_we = (r_state == S_MERGE);
        mrg_wdata = take_a ? cur_a : cur_b;
        merge_done = (r_k + CW'(1) == r_hi);

        sum_mid = SW'(r_lo) + SW'(r_width);
        sum_hi  = SW'(r_lo) + (SW'(r_width) << 1);
        next_lo = sum_hi;
        c_mid = (sum_mid > SW'(r_n)) ? r_n : sum_mid[CW-1:0];
        c_hi  = (sum_hi > SW'(r_n)) ? r_n : sum_hi[CW-1:0];
        n_width = r_width << 1;

        unique case (r_state)
            S_INIT: begin
                raddr0 = r_lo[AW-1:0];
                raddr1 = c_mid[AW-1:0];
            end
            S_MERGE: begin
                raddr0 = n_i[AW-1:0];
                raddr1 = n_j[AW-1:0];
            end
            S_OUT: begin
                raddr0 = r_k[AW-1:0];
                raddr1 = r_k[AW-1:0];
            end
            default: begin
                raddr0 = r_k[AW-1:0];
                raddr1 = r_k[AW-1:0];
            end
        endcase

        a_we    = i_load_we || (mrg_we && r_src_b);
        a_waddr = i_load_we ? i_load_addr : r_k[AW-1:0];
        a_wdata = i_load_we ? i_load_data : mrg_wdata;
        b_we    = mrg_we && !r_src_b;
    end

    mse_store #(
        .MAX_ITEMS (MAX_ITEMS),
        .WORD_BITS (WORD_BITS)
    ) u_store_a (
        .i_clk    (i_clk),
        .i_we     (a_we),
        .i_waddr  (a_waddr),
        .i_wdata  (a_wdata),
        .i_raddr0 (raddr0),
        .i_raddr1 (raddr1),
        .o_rdata0 (a_rd0),
        .o_rdata1 (a_rd1)
    );

    mse_store #(
        .MAX_ITEMS (MAX_ITEMS),
        .WORD_BITS (WORD_BITS)
    ) u_store_b (
        .i_clk    (i_clk),
        .i_we     (b_we),
        .i_waddr  (r_k[AW-1:0]),
        .i_wdata  (mrg_wdata),
        .i_raddr0 (raddr0),
        .i_raddr1 (raddr1),
        .o_rdata0 (b_rd0),
        .o_rdata1 (b_rd1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
            r_src_b  <= 1'b0;
            r_load_a <= 1'b0;
            r_load_b <= 1'b0;
        end else begin
            r_strobe <= (r_state == S_OUT);
            unique case (r_state)
                S_IDLE: begin
                    if (i_ctl.go) begin
                        r_n     <= i_count;
                        r_ovf   <= i_ctl.ovf;
                        r_src_b <= 1'b0;
                        r_width <= WW'(1);
                        r_lo    <= '0;
                        r_k     <= '0;
                        r_state <= (i_count == CW'(1)) ? S_OUT : S_INIT;
                    end
                end
                S_INIT: begin
                    r_i      <= r_lo;
                    r_j      <= c_mid;
                    r_k      <= r_lo;
                    r_mid    <= c_mid;
                    r_hi     <= c_hi;
                    r_load_a <= 1'b1;
                    r_load_b <= 1'b1;
                    r_state  <= S_MERGE;
                end
                S_MERGE: begin
                    r_head_a <= cur_a;
                    r_head_b <= cur_b;
                    r_load_a <= take_a;
                    r_load_b <= !take_a;
                    r_i      <= n_i;
                    r_j      <= n_j;
                    // Rewind the output index when the final pass ends.
                    if (merge_done && (next_lo >= SW'(r_n)) && (n_width >= WW'(r_n))) begin
                        r_k <= '0;
                    end else begin
                        r_k <= r_k + CW'(1);
                    end
                    if (merge_done) begin
                        if (next_lo >= SW'(r_n)) begin
                            // Pass complete: swap stores and double the run length.
                            r_src_b <= !r_src_b;
                            r_width <= n_width;
                            r_lo    <= '0;
                            if (n_width >= WW'(r_n)) begin
                                r_state <= S_OUT;
                            end else begin
                                r_state <= S_INIT;
                            end
                        end else begin
                            r_lo    <= next_lo[CW-1:0];
                            r_state <= S_INIT;
                        end
                    end
                end
                S_OUT: begin
                    r_out_last <= (r_k + CW'(1) == r_n);
                    r_k        <= r_k + CW'(1);
                    if (r_k + CW'(1) == r_n) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_active    = (r_state != S_IDLE);
    assign o_strobe    = r_strobe;
    assign o_value_res = $signed(rd0);
    assign o_last_res  = r_out_last;
    assign o_overflow  = r_ovf;

    `MSE_ASSERT_NEXT(a_last_ends_burst, i_clk, i_rst_n, r_strobe && r_out_last, !r_strobe)
    `MSE_ASSERT_SAME(a_go_when_idle, i_clk, i_rst_n, i_ctl.go, r_state == S_IDLE)
    `MSE_ASSERT_SAME(a_merge_in_range, i_clk, i_rst_n, r_state == S_MERGE, r_k < r_hi)
    `MSE_ASSERT_SAME(a_merge_has_word, i_clk, i_rst_n, r_state == S_MERGE, a_ok || b_ok)

endmodule

`default_nettype wire

// ===== design/merge_sort_engine_core.sv =====
// Loading: one word per cycle while busy is low; start with i_last closes the batch.
// Sorting: ceil(log2 n) merge passes, one word a cycle through the dual-read store
// except in the init step before each run pair; then n results, one per cycle, once
// the last pass ends. Cost is set by the single write port of the stores.
// The receiver cannot stall; results are strobed for one cycle each.
// Synchronous reset clears the load counter and control state; store contents are not cleared.
`default_nettype none

module merge_sort_engine_core #(
    parameter int MAX_ITEMS = 64,
    parameter int WORD_BITS = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic signed [WORD_BITS-1:0] i_value,
    input  wire logic                        i_last,
    output logic                             o_strobe,
    output logic signed [WORD_BITS-1:0]      o_value_res,
    output logic                             o_last_res,
    output logic                             o_overflow
);

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);

    logic [CW-1:0]       r_count;
    logic                r_dropped;
    logic                accept;
    logic                room;
    logic                load_we;
    logic [CW-1:0]       batch_n;
    logic                active;
    mse_pkg::t_batch_ctl ctl;

    always_comb begin
        accept   = start && !busy;
        room     = (r_count < CW'(MAX_ITEMS));
        load_we  = accept && room;
        batch_n  = load_we ? r_count + CW'(1) : r_count;
        ctl.go   = accept && i_last;
        ctl.ovf  = r_dropped || (accept && !room);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_dropped <= 1'b0;
        end else if (ctl.go) begin
            r_count   <= '0;
            r_dropped <= 1'b0;
        end else if (load_we) begin
            r_count <= r_count + CW'(1);
        end else if (accept) begin
            // Store full: drop the word and flag the batch.
            r_dropped <= 1'b1;
        end
    end

    mse_sorter #(
        .MAX_ITEMS (MAX_ITEMS),
        .WORD_BITS (WORD_BITS)
    ) u_sorter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_count     (batch_n),
        .i_load_we   (load_we),
        .i_load_addr (r_count[AW-1:0]),
        .i_load_data (i_value),
        .o_active    (active),
        .o_strobe    (o_strobe),
        .o_value_res (o_value_res),
        .o_last_res  (o_last_res),
        .o_overflow  (o_overflow)
    );

    assign busy = active;

endmodule

`default_nettype wire
